// File: rtl/bcal_pkg.sv
// Shared types and constants for the client address learner.
package bcal_pkg;

  // Width of a station or access-point address.
  localparam int unsigned ADDR_W = 48;
  // Width of the reported entry count.
  localparam int unsigned HELD_W = 7;
  // Configuration port widths.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 64;

  // The broadcast address is all ones.
  localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};

  // Register index of the access-point address (byte address bit 3).
  localparam logic REG_AP_ADDR = 1'b0;

  // Sequencer states of the learning engine.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

endpackage

// File: rtl/bcal_if.sv
// Valid/ready channels for frame address words and learning result words.
interface bcal_in_if;
  import bcal_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] source_address;
  logic [ADDR_W-1:0] destination_address;

  modport source (output valid, output source_address, output destination_address,
                  input ready);
  modport sink (input valid, input source_address, input destination_address,
                output ready);
endinterface

interface bcal_out_if;
  import bcal_pkg::*;
  logic              valid;
  logic              ready;
  logic              candidate_seen;
  logic              newly_added;
  logic              table_full_drop;
  logic [ADDR_W-1:0] client_address;
  logic [HELD_W-1:0] entries_held;

  modport source (output valid, output candidate_seen, output newly_added,
                  output table_full_drop, output client_address, output entries_held,
                  input ready);
  modport sink (input valid, input candidate_seen, input newly_added,
                input table_full_drop, input client_address, input entries_held,
                output ready);
endinterface

// File: rtl/bcal_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bcal_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bcal_cfg.sv
// APB register block holding the access-point address.
module bcal_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcal_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcal_pkg::PDATA_W-1:0]  pwdata,
  output logic [bcal_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [bcal_pkg::ADDR_W-1:0]   ap_addr_o
);
  import bcal_pkg::*;

  logic [ADDR_W-1:0] ap_addr_q;
  logic              sel_ap;

  // Registers are eight bytes apart; bit 3 selects the register.
  assign sel_ap = (paddr[3] == REG_AP_ADDR);
  assign pready = 1'b1;

  // Register write at the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ap_addr_q <= '0;
    end else if (psel && penable && pwrite && sel_ap) begin
      ap_addr_q <= pwdata[ADDR_W-1:0];
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    if (sel_ap) begin
      prdata = PDATA_W'(ap_addr_q);
    end
  end

  assign ap_addr_o = ap_addr_q;

endmodule

// File: rtl/bcal_engine.sv
// Learning sequencer: picks the candidate, scans the table memory and appends.
module bcal_engine #(
  parameter int unsigned TABLE_DEPTH = 64,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bcal_pkg::ADDR_W-1:0] ap_addr_i,
  bcal_in_if.sink                     in_i,
  bcal_out_if.source                  out_o,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [bcal_pkg::ADDR_W-1:0] ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [bcal_pkg::ADDR_W-1:0] ram_rdata_i
);
  import bcal_pkg::*;

  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cand_q, cand_d;
  logic              seen_q, seen_d;
  logic              found_q, found_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic [CW-1:0]     count_q, count_d;

  logic              out_valid_q, out_valid_d;
  logic              out_seen_q, out_seen_d;
  logic              out_added_q, out_added_d;
  logic              out_drop_q, out_drop_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [HELD_W-1:0] out_held_q, out_held_d;

  logic              bcast;
  logic              dst_is_ap;
  logic              src_is_ap;
  logic              hit;
  logic              issue;
  logic              room;
  logic              add;
  logic              out_free;

  // Candidate selection on the incoming word.
  assign bcast     = (in_i.source_address == BCAST_ADDR) ||
                     (in_i.destination_address == BCAST_ADDR) ||
                     (in_i.source_address == in_i.destination_address);
  assign dst_is_ap = (in_i.destination_address == ap_addr_i);
  assign src_is_ap = (in_i.source_address == ap_addr_i);

  // Scan compare and read issue; valid entries are always 0 .. count-1.
  assign hit      = pend_q && (ram_rdata_i == cand_q);
  assign issue    = (state_q == ST_SCAN) && (iss_q < count_q) && !hit;
  assign room     = (count_q < DepthC);
  assign add      = (state_q == ST_DECIDE) && seen_q && !found_q && room;
  assign out_free = !out_valid_q || out_o.ready;

  assign ram_re_o    = issue;
  assign ram_raddr_o = iss_q[AW-1:0];
  assign ram_we_o    = add && out_free;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = cand_q;

  assign in_i.ready = (state_q == ST_IDLE);

  // Next state and datapath.
  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    seen_d      = seen_q;
    found_d     = found_q;
    pend_d      = issue;
    iss_d       = issue ? iss_q + 1'b1 : iss_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_seen_d  = out_seen_q;
    out_added_d = out_added_q;
    out_drop_d  = out_drop_q;
    out_addr_d  = out_addr_q;
    out_held_d  = out_held_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          seen_d  = !bcast && (dst_is_ap || src_is_ap);
          cand_d  = '0;
          if (!bcast && dst_is_ap) begin
            cand_d = in_i.source_address;
          end else if (!bcast && src_is_ap) begin
            cand_d = in_i.destination_address;
          end
          found_d = 1'b0;
          iss_d   = '0;
          pend_d  = 1'b0;
          state_d = seen_d ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
          state_d = ST_DECIDE;
        end else if (!pend_q && (iss_q == count_q)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (add) begin
            count_d = count_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_seen_d  = seen_q;
          out_added_d = add;
          out_drop_d  = seen_q && !found_q && !room;
          out_addr_d  = cand_q;
          out_held_d  = HELD_W'(count_d);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      iss_q       <= '0;
      found_q     <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      iss_q       <= iss_d;
      found_q     <= found_d;
      seen_q      <= seen_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    out_seen_q  <= out_seen_d;
    out_added_q <= out_added_d;
    out_drop_q  <= out_drop_d;
    out_addr_q  <= out_addr_d;
    out_held_q  <= out_held_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.candidate_seen  = out_seen_q;
  assign out_o.newly_added     = out_added_q;
  assign out_o.table_full_drop = out_drop_q;
  assign out_o.client_address  = out_addr_q;
  assign out_o.entries_held    = out_held_q;

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC) else $error("entry count above table depth");

  // A table write always grows the count by exactly one.
  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (count_q == $past(count_q) + 1'b1))
    else $error("table write without count increment");

  // A drop is only reported with a full table.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_drop_q) |-> (count_q == DepthC))
    else $error("drop reported with free entries");

  // A new entry or a drop always comes with a candidate.
  a_flags_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_added_q || out_drop_q)) |-> out_seen_q)
    else $error("add or drop flag without candidate");

endmodule

// File: rtl/bssid_client_address_learner_unit.sv
// Sequence: a frame with no candidate goes from acceptance to the decide state and then to the
// registered result; with a candidate, the table is scanned first and the scan stops on a match
// in entry k (counting from 0), or after one read per held entry plus a drain; then it decides.
// Throughput: one word at a time; the next word can be taken in the cycle in which the result is
// presented, a stalled result holds the decide state, and the one-entry-per-cycle scan sets the rest.
// Reset: the access-point address and the fill count clear; the table memory is not
// cleared, since entries at or above the fill count are never read. No clearing pass.
module bssid_client_address_learner_unit #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bcal_in_if.sink                       in_i,
  bcal_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcal_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcal_pkg::PDATA_W-1:0]  pwdata,
  output logic [bcal_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import bcal_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [ADDR_W-1:0] ap_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  // Configuration registers.
  bcal_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ap_addr_o (ap_addr)
  );

  // Learning sequencer.
  bcal_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ap_addr_i   (ap_addr),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Client address table.
  bcal_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: tb/sv/bssid_client_address_learner_unit_tb.sv
// Self-checking testbench for the client address learner: directed and random frames.
`timescale 1ns / 100ps

module bssid_client_address_learner_unit_tb;
  import bcal_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned POOL_SIZE = 96;
  localparam int unsigned PHASE_WORDS = 112;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Register addresses: the access-point address and one unused slot past it.
  localparam logic [PADDR_W-1:0] AP_PADDR = {REG_AP_ADDR, 3'b000};
  localparam logic [PADDR_W-1:0] SPARE_PADDR = 4'h8;

  typedef logic [ADDR_W-1:0] addr_t;

  // One result word, in field order.
  typedef struct packed {
    logic              seen;
    logic              added;
    logic              dropped;
    addr_t             client;
    logic [HELD_W-1:0] held;
  } learn_result_t;

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_SET_AP,
    ROW_SET_SPARE
  } row_kind_e;

  // One line of the directed stimulus; for register rows src holds the value.
  typedef struct {
    row_kind_e     kind;
    addr_t         src;
    addr_t         dst;
    bit            typed;
    learn_result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bcal_in_if  frame_bus ();
  bcal_out_if learn_bus ();

  // Shadow of the learning table and the access-point register.
  addr_t       ap_shadow;
  addr_t       known_clients [TABLE_DEPTH];
  bit          client_valid [TABLE_DEPTH];
  int unsigned learned_count;

  learn_result_t expected_results [$];
  stim_row_t     directed_rows [$];
  addr_t         client_pool [POOL_SIZE];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;

  bssid_client_address_learner_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (frame_bus),
    .out_o  (learn_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("bssid_client_address_learner_unit test failed");
      $finish;
    end
  end

  // The receiver stalls at random with the current phase's rate.
  always @(negedge clk_i) begin
    learn_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Predicts one result word and updates the shadow table.
  function automatic learn_result_t predict_learning(input addr_t src, input addr_t dst);
    learn_result_t res;
    bit known;
    int slot;
    res = '0;
    known = 1'b0;
    slot = -1;
    if (src != BCAST_ADDR && dst != BCAST_ADDR && src != dst) begin
      if (dst == ap_shadow) begin
        res.seen = 1'b1;
        res.client = src;
      end else if (src == ap_shadow) begin
        res.seen = 1'b1;
        res.client = dst;
      end
    end
    if (res.seen) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (client_valid[i] && known_clients[i] == res.client) known = 1'b1;
        if (!client_valid[i] && slot < 0) slot = i;
      end
      if (!known) begin
        if (slot >= 0) begin
          known_clients[slot] = res.client;
          client_valid[slot] = 1'b1;
          learned_count++;
          res.added = 1'b1;
        end else begin
          res.dropped = 1'b1;
        end
      end
    end
    res.held = learned_count[HELD_W-1:0];
    return res;
  endfunction

  // Checks every accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    learn_result_t want;
    if (rst_ni && learn_bus.valid === 1'b1 && learn_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected", learn_bus.client_address, 0);
      end else begin
        want = expected_results.pop_front();
        if (learn_bus.candidate_seen !== want.seen)
          report_mismatch("candidate_seen", learn_bus.candidate_seen, want.seen);
        if (learn_bus.newly_added !== want.added)
          report_mismatch("newly_added", learn_bus.newly_added, want.added);
        if (learn_bus.table_full_drop !== want.dropped)
          report_mismatch("table_full_drop", learn_bus.table_full_drop, want.dropped);
        if (learn_bus.client_address !== want.client)
          report_mismatch("client_address", learn_bus.client_address, want.client);
        if (learn_bus.entries_held !== want.held)
          report_mismatch("entries_held", learn_bus.entries_held, want.held);
      end
    end
  end

  function automatic addr_t rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  // Presents one frame word after a random gap and records its expectation.
  task automatic send_frame(input addr_t src, input addr_t dst, input bit typed,
                            input learn_result_t want);
    learn_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      frame_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    frame_bus.valid <= 1'b1;
    frame_bus.source_address <= src;
    frame_bus.destination_address <= dst;
    @(posedge clk_i);
    while (!frame_bus.ready) @(posedge clk_i);
    res = predict_learning(src, dst);
    expected_results.push_back(typed ? want : res);
  endtask

  // Drops valid and waits until every expected word has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    frame_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes a register once the block is idle, then reads the access-point address back.
  task automatic program_register(input logic [PADDR_W-1:0] addr, input addr_t value);
    wait_drained();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(PDATA_W-ADDR_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr[3] == REG_AP_ADDR) ap_shadow = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= AP_PADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(PDATA_W-ADDR_W){1'b0}}, ap_shadow})
      report_mismatch("access point address readback", prdata, ap_shadow);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random frame: mostly well-formed traffic to or from the access point.
  function automatic void pick_frame(output addr_t src, output addr_t dst);
    int unsigned roll;
    addr_t client;
    roll = $urandom_range(99);
    client = client_pool[$urandom_range(POOL_SIZE-1)];
    if (roll < 70) begin
      if ($urandom_range(1)) begin
        src = client;
        dst = ap_shadow;
      end else begin
        src = ap_shadow;
        dst = client;
      end
    end else if (roll < 78) begin
      src = BCAST_ADDR;
      dst = $urandom_range(1) ? ap_shadow : rand_addr();
      if ($urandom_range(1)) begin
        src = dst;
        dst = BCAST_ADDR;
      end
    end else if (roll < 86) begin
      src = $urandom_range(1) ? ap_shadow : rand_addr();
      dst = src;
    end else begin
      src = rand_addr();
      dst = rand_addr();
    end
  endfunction

  initial begin
    addr_t src;
    addr_t dst;
    addr_t ap_value;
    stim_row_t row;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    frame_bus.valid = 1'b0;
    frame_bus.source_address = '0;
    frame_bus.destination_address = '0;
    learn_bus.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    sender_idle_pct = 20;
    sink_stall_pct = 20;
    ap_shadow = '0;
    learned_count = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      client_valid[i] = 1'b0;
      known_clients[i] = '0;
    end

    // Client pool: random stations plus the zero, near-broadcast and unit addresses.
    for (int i = 0; i < POOL_SIZE; i++) client_pool[i] = rand_addr();
    client_pool[0] = '0;
    client_pool[1] = 48'hffff_ffff_fffe;
    client_pool[2] = 48'h0000_0000_0001;

    // Directed rows; the access point starts at its reset value of zero.
    directed_rows.push_back('{ROW_FRAME, BCAST_ADDR, 48'h0, 1'b1, {3'b000, 48'h0, 7'd0}});
    directed_rows.push_back('{ROW_FRAME, 48'h0, BCAST_ADDR, 1'b1, {3'b000, 48'h0, 7'd0}});
    directed_rows.push_back('{ROW_FRAME, 48'h0, 48'h0, 1'b1, {3'b000, 48'h0, 7'd0}});
    directed_rows.push_back('{ROW_FRAME, 48'h1, 48'h2, 1'b1, {3'b000, 48'h0, 7'd0}});
    directed_rows.push_back('{ROW_FRAME, 48'h1234_5678_9abc, 48'h0, 1'b1,
                              {3'b110, 48'h1234_5678_9abc, 7'd1}});
    directed_rows.push_back('{ROW_FRAME, 48'h1234_5678_9abc, 48'h0, 1'b1,
                              {3'b100, 48'h1234_5678_9abc, 7'd1}});
    directed_rows.push_back('{ROW_FRAME, 48'h0, 48'hffff_ffff_fffe, 1'b1,
                              {3'b110, 48'hffff_ffff_fffe, 7'd2}});
    directed_rows.push_back('{ROW_FRAME, 48'h8000_0000_0000, 48'h0, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h0, 48'h7fff_ffff_ffff, 1'b0, '0});
    // A write past the last register must leave the access point alone.
    directed_rows.push_back('{ROW_SET_SPARE, 48'h5a5a_5a5a_5a5a, 48'h0, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h5a5a_5a5a_5a5a, 48'h0, 1'b0, '0});
    directed_rows.push_back('{ROW_SET_AP, 48'h0a0b_0c0d_0e0f, 48'h0, 1'b0, '0});
    // The zero address is an ordinary client.
    directed_rows.push_back('{ROW_FRAME, 48'h0, 48'h0a0b_0c0d_0e0f, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h0a0b_0c0d_0e0f, 48'h0, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h0a0b_0c0d_0e0f, 48'h0a0b_0c0d_0e0f, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h0a0b_0c0d_0e0f, BCAST_ADDR, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h0, 48'h1, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h0a0b_0c0d_0e0f, 48'h1234_5678_9abc, 1'b0, '0});
    // Broadcast access point: nothing can be learned.
    directed_rows.push_back('{ROW_SET_AP, BCAST_ADDR, 48'h0, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, 48'h1, BCAST_ADDR, 1'b0, '0});
    directed_rows.push_back('{ROW_FRAME, BCAST_ADDR, 48'h3, 1'b0, '0});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_FRAME: begin
          send_frame(row.src, row.dst, row.typed, row.want);
        end
        ROW_SET_AP: begin
          program_register(AP_PADDR, row.src);
        end
        default: begin
          program_register(SPARE_PADDR, row.src);
        end
      endcase
    end

    // Random part: four idling regimes, each with its own access point.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct = 0;
          ap_value = rand_addr();
        end
        1: begin
          sender_idle_pct = 88;
          sink_stall_pct = 0;
          ap_value = '0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct = 88;
          ap_value = 48'hffff_ffff_fffe;
        end
        default: begin
          sender_idle_pct = 38;
          sink_stall_pct = 38;
          ap_value = rand_addr();
        end
      endcase
      program_register(AP_PADDR, ap_value);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Midway through each phase the sender holds off until all results are in.
        if (n == PHASE_WORDS / 2) wait_drained();
        pick_frame(src, dst);
        send_frame(src, dst, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TABLE_DEPTH + 16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bssid_client_address_learner_unit test passed");
    end else begin
      $display("bssid_client_address_learner_unit test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bcal_pkg.sv
rtl/bcal_if.sv
rtl/bcal_ram.sv
rtl/bcal_cfg.sv
rtl/bcal_engine.sv
rtl/bssid_client_address_learner_unit.sv
tb/sv/bssid_client_address_learner_unit_tb.sv
